### rtl/qph_pkg.sv
// Shared types and codes for the quadratic probe hash table.
package qph_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int KEY_W           = 32;
    localparam int SLOT_W          = 4;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
    } t_qph_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
    } t_qph_out;

endpackage

### rtl/qph_slot_ram.sv
// Slot memory: one write port, one read port with registered read data.
module qph_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 34
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/quadratic_probe_hash_table_core.sv
// Probing: one slot is visited per S_CHK step (1 to TABLE_SLOTS probes); the last probe loads
//   the output register, or S_DONE holds the result while the output is stalled. When TABLE_SLOTS
//   is not a power of two, S_MOD first reduces the key mod TABLE_SLOTS, four key bits a cycle.
// Requests: one at a time; an unknown mode skips probing and answers STAT_NOT_FOUND via S_DONE.
//   The next request is taken in the cycle after the result loads; a stalled result holds the core busy.
// Reset: synchronous; a clearing pass over all TABLE_SLOTS slots follows, with o_in_stall high.
module quadratic_probe_hash_table_core
    import qph_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_qph_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_qph_out o_out
);

    localparam int SW       = $clog2(TABLE_SLOTS);
    localparam int DIGITS   = (KEY_BITS + 3) / 4;
    localparam int KPW      = 4 * DIGITS;
    localparam int DGW      = $clog2(DIGITS);
    localparam int MW       = KEY_BITS + 2;
    localparam bit IS_POW2  = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [SW:0]   N_EXT     = (SW+1)'(TABLE_SLOTS);
    localparam logic [SW+3:0] N_X1      = (SW+4)'(TABLE_SLOTS);
    localparam logic [SW+3:0] N_X2      = (SW+4)'(TABLE_SLOTS * 2);
    localparam logic [SW+3:0] N_X4      = (SW+4)'(TABLE_SLOTS * 4);
    localparam logic [SW+3:0] N_X8      = (SW+4)'(TABLE_SLOTS * 8);
    localparam logic [SW-1:0] SLOT_LAST = SW'(TABLE_SLOTS - 1);
    localparam logic [DGW-1:0] DIG_LAST = DGW'(DIGITS - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [SW-1:0]       r_slot, n_slot;
    logic [SW-1:0]       r_odd, n_odd;
    logic [SW-1:0]       r_step, n_step;
    logic [DGW-1:0]      r_dig, n_dig;
    logic [SW-1:0]       r_rem, n_rem;
    logic [KPW-1:0]      r_kshift, n_kshift;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [1:0]          r_mode, n_mode;
    t_qph_out            r_res, n_res;
    t_qph_out            r_out, n_out;
    logic                r_ovalid, n_ovalid;

    logic [MW-1:0]       w_rd;
    logic                w_we;
    logic [MW-1:0]       w_wdata;
    logic [KEY_BITS-1:0] w_key;
    logic [SW+3:0]       w_racc, w_rs8, w_rs4, w_rs2;
    logic [SW:0]         w_sum, w_osum;
    logic [SW-1:0]       w_rem_red, w_slot_adv, w_odd_adv;
    logic                w_used, w_tomb, w_match, w_out_free;
    logic                w_fin;
    t_qph_out            w_fin_res;

    assign w_key  = KEY_BITS'(i_in.key);
    assign w_used = w_rd[MW-1];
    assign w_tomb = w_rd[MW-2];
    assign w_match = (w_rd[KEY_BITS-1:0] == r_key);
    assign w_out_free = !r_ovalid || !i_out_stall;

    // Fold in four key bits a cycle: shift the remainder in, then compare-subtract 8N, 4N, 2N, N.
    assign w_racc    = {r_rem, r_kshift[KPW-1 -: 4]};
    assign w_rs8     = (w_racc >= N_X8) ? (w_racc - N_X8) : w_racc;
    assign w_rs4     = (w_rs8 >= N_X4) ? (w_rs8 - N_X4) : w_rs8;
    assign w_rs2     = (w_rs4 >= N_X2) ? (w_rs4 - N_X2) : w_rs4;
    assign w_rem_red = (w_rs2 >= N_X1) ? SW'(w_rs2 - N_X1) : SW'(w_rs2);

    // Advance the probe by the next odd step and the odd step itself by two, each wrapped once.
    assign w_sum = {1'b0, r_slot} + {1'b0, r_odd};
    assign w_slot_adv = (w_sum >= N_EXT) ? SW'(w_sum - N_EXT) : SW'(w_sum);
    assign w_osum = {1'b0, r_odd} + (SW+1)'(2);
    assign w_odd_adv = (w_osum >= N_EXT) ? SW'(w_osum - N_EXT) : SW'(w_osum);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_odd     = r_odd;
        n_step    = r_step;
        n_dig     = r_dig;
        n_rem     = r_rem;
        n_kshift  = r_kshift;
        n_key     = r_key;
        n_mode    = r_mode;
        n_res     = r_res;
        n_out     = r_out;
        n_ovalid  = r_ovalid && i_out_stall;
        w_we      = 1'b0;
        w_wdata   = '0;
        w_fin     = 1'b0;
        w_fin_res = '0;

        unique case (r_state)
            S_CLR: begin
                w_we   = 1'b1;
                n_slot = r_slot + SW'(1);
                if (r_slot == SLOT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_in.mode;
                    n_key    = w_key;
                    n_kshift = KPW'(w_key);
                    n_step   = '0;
                    n_odd    = SW'(1);
                    n_rem    = '0;
                    n_dig    = '0;
                    if (i_in.mode == MODE_INSERT || i_in.mode == MODE_SEARCH ||
                        i_in.mode == MODE_REMOVE) begin
                        if (IS_POW2) begin
                            n_slot  = SW'(w_key);
                            n_state = S_CHK;
                        end else begin
                            n_state = S_MOD;
                        end
                    end else begin
                        n_res.status = STAT_NOT_FOUND;
                        n_res.slot   = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_MOD: begin
                n_rem    = w_rem_red;
                n_kshift = r_kshift << 4;
                n_dig    = r_dig + DGW'(1);
                if (r_dig == DIG_LAST) begin
                    n_slot  = w_rem_red;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_mode == MODE_INSERT) begin
                    if (!w_used || w_tomb) begin
                        w_we      = 1'b1;
                        w_wdata   = {1'b1, 1'b0, r_key};
                        w_fin     = 1'b1;
                        w_fin_res = '{status: STAT_OK, slot: SLOT_W'(r_slot)};
                    end
                end else begin
                    if (!w_used) begin
                        w_fin     = 1'b1;
                        w_fin_res = '{status: STAT_NOT_FOUND, slot: '0};
                    end else if (!w_tomb && w_match) begin
                        // Remove leaves a tombstone so later probe paths stay intact.
                        w_we      = (r_mode == MODE_REMOVE);
                        w_wdata   = {1'b1, 1'b1, w_rd[KEY_BITS-1:0]};
                        w_fin     = 1'b1;
                        w_fin_res = '{status: STAT_OK, slot: SLOT_W'(r_slot)};
                    end
                end
                if (!w_fin) begin
                    if (r_step == SLOT_LAST) begin
                        w_fin = 1'b1;
                        w_fin_res.status = (r_mode == MODE_INSERT) ? STAT_FULL
                                                                   : STAT_NOT_FOUND;
                        w_fin_res.slot   = '0;
                    end else begin
                        n_slot = w_slot_adv;
                        n_odd  = w_odd_adv;
                        n_step = r_step + SW'(1);
                    end
                end
                if (w_fin) begin
                    if (w_out_free) begin
                        n_out    = w_fin_res;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_res   = w_fin_res;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_slot   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_ovalid <= n_ovalid;
        end
        r_odd    <= n_odd;
        r_step   <= n_step;
        r_dig    <= n_dig;
        r_rem    <= n_rem;
        r_kshift <= n_kshift;
        r_key    <= n_key;
        r_mode   <= n_mode;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // Read the slot that r_slot will hold, so its word is ready in the next cycle.
    qph_slot_ram #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (MW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (w_wdata),
        .i_raddr (n_slot),
        .o_rdata (w_rd)
    );

endmodule

### rtl/qph_checker.sv
// Port-level checks for the quadratic probe hash table, bound to the top level.
module qph_checker
    import qph_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_qph_in  i_in,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_qph_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != STAT_OK |-> o_out.slot == '0)
        else $error("nonzero slot with failing status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status == STAT_OK || o_out.status == STAT_NOT_FOUND ||
                        o_out.status == STAT_FULL)
        else $error("undefined status code");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one in progress");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken before the clearing pass");

endmodule

bind quadratic_probe_hash_table_core qph_checker u_qph_checker (.*);

### test/hash_table_checker.sv
// Checker for the hash table core: tracks the table, predicts each answer and compares.
`timescale 1ns / 1ps

module hash_table_checker
    import qph_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_qph_in  i_in,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_qph_out i_out,
    output int       o_errors,
    output int       o_pending
);

    localparam int SLOTS = TABLE_SLOTS_DEF;

    logic [KEY_W-1:0] slot_keys [SLOTS];
    logic             slot_live [SLOTS];
    logic             slot_dead [SLOTS];

    t_qph_out answer_q [$];
    int       error_count = 0;

    // Walk the quadratic probe path and update the table as the core should.
    function automatic t_qph_out apply_request(t_qph_in req);
        t_qph_out          rsp;
        logic [SLOT_W-1:0] home;
        logic [SLOT_W-1:0] probe;
        bit                done;
        rsp.status = STAT_NOT_FOUND;
        rsp.slot   = '0;
        done       = 1'b0;
        home       = req.key[SLOT_W-1:0];
        case (req.mode) inside
            MODE_INSERT: begin
                rsp.status = STAT_FULL;
                for (int i = 0; i < SLOTS && !done; i++) begin
                    probe = home + SLOT_W'(i * i);
                    if (!slot_live[probe] || slot_dead[probe]) begin
                        slot_keys[probe] = req.key;
                        slot_live[probe] = 1'b1;
                        slot_dead[probe] = 1'b0;
                        rsp.status       = STAT_OK;
                        rsp.slot         = probe;
                        done             = 1'b1;
                    end
                end
            end
            MODE_SEARCH, MODE_REMOVE: begin
                for (int i = 0; i < SLOTS && !done; i++) begin
                    probe = home + SLOT_W'(i * i);
                    if (!slot_live[probe]) begin
                        done = 1'b1;
                    end else if (!slot_dead[probe] && slot_keys[probe] == req.key) begin
                        if (req.mode == MODE_REMOVE) slot_dead[probe] = 1'b1;
                        rsp.status = STAT_OK;
                        rsp.slot   = probe;
                        done       = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    assign o_errors = error_count;

    always @(posedge i_clk) begin
        t_qph_out want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_live[s] = 1'b0;
                slot_dead[s] = 1'b0;
                slot_keys[s] = '0;
            end
            answer_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) answer_q.push_back(apply_request(i_in));
            if (i_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected result: status %0d slot %0d", i_out.status, i_out.slot);
                    error_count = error_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (i_out.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, i_out.status);
                        error_count = error_count + 1;
                    end
                    if (i_out.slot !== want.slot) begin
                        $error("slot mismatch: expected %0d, got %0d", want.slot, i_out.slot);
                        error_count = error_count + 1;
                    end
                end
            end
        end
        o_pending = answer_q.size();
    end

endmodule

### test/testbench.sv
// Top of the hash table testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import qph_pkg::*;

    localparam logic [1:0] MODE_UNKNOWN = 2'd3;
    localparam int RANDOM_ITEMS = 1725;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 600000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_qph_in  i_in = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_qph_out o_out;

    int errors;
    int pending;
    int cycle_count = 0;
    int stall_left = 0;
    int gap_odds = 0;
    int stall_odds = 0;

    logic [KEY_W-1:0]        recent_keys [$];
    logic [KEY_W-SLOT_W-1:0] high_parts [4];
    t_qph_in                 directed_q [$];

    always #2 i_clk = ~i_clk;

    quadratic_probe_hash_table_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    hash_table_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out       (o_out),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver back-pressure in bursts.
    always @(negedge i_clk) begin
        if (stall_left == 0 && $urandom_range(0, 7) < stall_odds)
            stall_left = $urandom_range(1, 19);
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic t_qph_in make_request(logic [1:0] mode, logic [KEY_W-1:0] key);
        t_qph_in req;
        req.mode = mode;
        req.key  = key;
        return req;
    endfunction

    // Mostly reuse stored keys or a few shared high parts so probe paths collide.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && recent_keys.size() != 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if (r < 8)
            return {high_parts[$urandom_range(0, 3)], SLOT_W'($urandom_range(0, 15))};
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7) return MODE_INSERT;
        if (r < 13) return MODE_SEARCH;
        if (r < 19) return MODE_REMOVE;
        return MODE_UNKNOWN;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(t_qph_in req);
        int gap;
        if ($urandom_range(0, 3) < gap_odds) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        t_qph_in req;
        high_parts[0] = '0;
        high_parts[1] = '1;
        high_parts[2] = $urandom;
        high_parts[3] = $urandom;

        // tombstones, reuse, extreme keys, unknown mode, full probe path
        directed_q.push_back(make_request(MODE_INSERT, 32'd0));
        directed_q.push_back(make_request(MODE_SEARCH, 32'd0));
        directed_q.push_back(make_request(MODE_INSERT, 32'd16));
        directed_q.push_back(make_request(MODE_REMOVE, 32'd0));
        directed_q.push_back(make_request(MODE_SEARCH, 32'd16));
        directed_q.push_back(make_request(MODE_SEARCH, 32'd0));
        directed_q.push_back(make_request(MODE_INSERT, 32'd32));
        directed_q.push_back(make_request(MODE_SEARCH, 32'd32));
        directed_q.push_back(make_request(MODE_INSERT, 32'hFFFF_FFFF));
        directed_q.push_back(make_request(MODE_SEARCH, 32'hFFFF_FFFF));
        directed_q.push_back(make_request(MODE_REMOVE, 32'hFFFF_FFFF));
        directed_q.push_back(make_request(MODE_REMOVE, 32'hFFFF_FFFF));
        directed_q.push_back(make_request(MODE_UNKNOWN, 32'hFFFF_FFFF));
        directed_q.push_back(make_request(MODE_INSERT, 32'd5));
        directed_q.push_back(make_request(MODE_INSERT, 32'd21));
        directed_q.push_back(make_request(MODE_INSERT, 32'd37));
        directed_q.push_back(make_request(MODE_INSERT, 32'd53));
        directed_q.push_back(make_request(MODE_INSERT, 32'd69));
        directed_q.push_back(make_request(MODE_SEARCH, 32'd69));
        directed_q.push_back(make_request(MODE_SEARCH, 32'd53));
        directed_q.push_back(make_request(MODE_REMOVE, 32'd21));
        directed_q.push_back(make_request(MODE_INSERT, 32'd69));
        directed_q.push_back(make_request(MODE_UNKNOWN, 32'd0));
        directed_q.push_back(make_request(MODE_INSERT, 32'hAAAA_AAAA));
        directed_q.push_back(make_request(MODE_SEARCH, 32'h5555_5555));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_odds   = 1;
        stall_odds = 1;
        foreach (directed_q[n]) send_request(directed_q[n]);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                gap_odds   = $urandom_range(0, 2);
                stall_odds = $urandom_range(0, 2);
            end
            if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            if (n % 400 == 399) drain();
            req = make_request(pick_mode(), pick_key());
            if (req.mode == MODE_INSERT) begin
                recent_keys.push_back(req.key);
                if (recent_keys.size() > 24) void'(recent_keys.pop_front());
            end
            send_request(req);
        end

        drain();
        repeat (40) @(negedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/qph_pkg.sv
rtl/qph_slot_ram.sv
rtl/quadratic_probe_hash_table_core.sv
rtl/qph_checker.sv
test/hash_table_checker.sv
test/testbench.sv
